>>> rtl/core/aar_pkg.sv
package aar_pkg;

	localparam int FRAC_BITS_DEF = 12;
	localparam int NRM_W         = 30;
	localparam int CORDIC_STEPS  = 20;
	localparam int DIV_STEPS     = 16;

	localparam logic signed [31:0] HALF_PI_Q28       = 32'sd421657428;
	localparam logic signed [31:0] PI_Q28            = 32'sd843314857;
	localparam logic signed [31:0] THREE_HALF_PI_Q28 = 32'sd1264972285;
	localparam logic [30:0]        TWO_PI_Q28        = 31'd1686629713;
	localparam logic signed [31:0] CORDIC_GAIN       = 32'sd163008219;
	localparam logic signed [15:0] ONE_Q14           = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] angle_scale;
	} aar_in_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic               zero_axis;
	} aar_out_t;

	// norm of the axis, FRAC_BITS+14 fraction bits
	typedef struct packed {
		logic [NRM_W-1:0] nrm;
		aar_in_t          item;
	} aar_nrm_t;

	typedef struct packed {
		logic signed [15:0] u0;
		logic signed [15:0] u1;
		logic signed [15:0] u2;
		logic [30:0]        ang;
		logic               neg;
		logic               zero;
	} aar_unit_t;

	typedef struct packed {
		logic signed [15:0] u0;
		logic signed [15:0] u1;
		logic signed [15:0] u2;
		logic signed [15:0] sn;
		logic signed [16:0] v;
		logic               zero;
	} aar_trig_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] a;
		case (i)
			5'd0:    a = 32'sd210828714;
			5'd1:    a = 32'sd124459458;
			5'd2:    a = 32'sd65760959;
			5'd3:    a = 32'sd33381290;
			5'd4:    a = 32'sd16755422;
			5'd5:    a = 32'sd8385879;
			5'd6:    a = 32'sd4193963;
			5'd7:    a = 32'sd2097109;
			5'd8:    a = 32'sd1048571;
			5'd9:    a = 32'sd524287;
			5'd10:   a = 32'sd262144;
			5'd11:   a = 32'sd131072;
			5'd12:   a = 32'sd65536;
			5'd13:   a = 32'sd32768;
			5'd14:   a = 32'sd16384;
			5'd15:   a = 32'sd8192;
			5'd16:   a = 32'sd4096;
			5'd17:   a = 32'sd2048;
			5'd18:   a = 32'sd1024;
			5'd19:   a = 32'sd512;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [15:0] sat_q14(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd16384) begin
			r = ONE_Q14;
		end else if (v < -48'sd16384) begin
			r = -ONE_Q14;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/aar_stream_if.sv
interface aar_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/aar_sqrt.sv
module aar_sqrt import aar_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	aar_stream_if.sink    up,
	aar_stream_if.source  dn
);

	// squares, sum, then one root bit per stage
	localparam int NS = 2 + NRM_W;

	typedef struct packed {
		logic [30:0]      p0;
		logic [30:0]      p1;
		logic [30:0]      p2;
		logic [31:0]      s;
		logic [33:0]      rem;
		logic [NRM_W-1:0] root;
		aar_in_t          item;
	} sq_stage_t;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;
	logic [NS-1:0] vld_nxt;
	sq_stage_t     stg_s [NS];
	sq_stage_t     nxt [NS];

	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || dn.ready;
		for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_s[k] || adv[k + 1];
	end

	assign vld_nxt  = {vld_s[NS-2:0], up.valid};
	assign up.ready = adv[0];
	assign dn.valid = vld_s[NS-1];
	assign dn.data  = '{nrm: stg_s[NS-1].root, item: stg_s[NS-1].item};

	always_comb begin
		logic signed [31:0] sx, sy, sz;
		logic [33:0]        rem2;
		logic [33:0]        trial;
		sx = up.data.axis_x * up.data.axis_x;
		sy = up.data.axis_y * up.data.axis_y;
		sz = up.data.axis_z * up.data.axis_z;
		nxt[0]      = '0;
		nxt[0].item = up.data;
		nxt[0].p0   = sx[30:0];
		nxt[0].p1   = sy[30:0];
		nxt[0].p2   = sz[30:0];

		nxt[1]      = stg_s[0];
		nxt[1].s    = 32'(stg_s[0].p0) + 32'(stg_s[0].p1) + 32'(stg_s[0].p2);
		nxt[1].rem  = '0;
		nxt[1].root = '0;

		// radicand is s followed by 28 zero bits; s shifts out two bits a step
		for (int k = 2; k < NS; k++) begin
			nxt[k]   = stg_s[k - 1];
			rem2     = {stg_s[k - 1].rem[31:0], stg_s[k - 1].s[31:30]};
			trial    = {2'b00, stg_s[k - 1].root, 2'b01};
			nxt[k].s = {stg_s[k - 1].s[29:0], 2'b00};
			if (rem2 >= trial) begin
				nxt[k].rem  = rem2 - trial;
				nxt[k].root = {stg_s[k - 1].root[NRM_W-2:0], 1'b1};
			end else begin
				nxt[k].rem  = rem2;
				nxt[k].root = {stg_s[k - 1].root[NRM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_s[k] <= vld_nxt[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (adv[k]) stg_s[k] <= nxt[k];
		end
	end

endmodule

>>> rtl/core/aar_div.sv
module aar_div import aar_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	aar_stream_if.sink    up,
	aar_stream_if.source  dn
);

	localparam int SH        = 2 * FRAC_BITS - 14;
	localparam int MAG_W     = 46 - SH;
	localparam int MOD_STEPS = (MAG_W > 31) ? MAG_W - 30 : 1;
	localparam int RW        = (MAG_W > 31) ? MAG_W : 31;
	localparam int NSTEP     = (MOD_STEPS > DIV_STEPS) ? MOD_STEPS : DIV_STEPS;
	// prepare, round angle, shared divide/modulo steps, clamp
	localparam int NS        = 3 + NSTEP;

	typedef struct packed {
		logic [45:0]        d0;
		logic [45:0]        d1;
		logic [45:0]        d2;
		logic [30:0]        dvs;
		logic [15:0]        q0;
		logic [15:0]        q1;
		logic [15:0]        q2;
		logic               sg0;
		logic               sg1;
		logic               sg2;
		logic signed [46:0] p;
		logic [RW-1:0]      mag;
		logic               neg;
		logic               zero;
	} dv_stage_t;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;
	logic [NS-1:0] vld_nxt;
	dv_stage_t     stg_s [NS-1];
	dv_stage_t     nxt [NS-1];
	aar_unit_t     res_s;
	aar_unit_t     res_nxt;

	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || dn.ready;
		for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_s[k] || adv[k + 1];
	end

	assign vld_nxt  = {vld_s[NS-2:0], up.valid};
	assign up.ready = adv[0];
	assign dn.valid = vld_s[NS-1];
	assign dn.data  = res_s;

	function automatic logic [15:0] mag16(input logic signed [15:0] w);
		return w[15] ? 16'(~w + 16'd1) : w;
	endfunction

	function automatic logic signed [15:0] unit_of(input logic [15:0] q, input logic sg);
		logic [15:0] qc;
		qc = (q > 16'd16384) ? 16'd16384 : q;
		return sg ? $signed(16'd0 - qc) : $signed(qc);
	endfunction

	always_comb begin
		logic [45:0] absp;
		logic [45:0] dsh;
		logic [RW-1:0] msh;
		int          b;
		int          m;
		nxt[0]      = '0;
		nxt[0].d0   = 46'({mag16(up.data.item.axis_x), 29'b0}) + 46'(up.data.nrm);
		nxt[0].d1   = 46'({mag16(up.data.item.axis_y), 29'b0}) + 46'(up.data.nrm);
		nxt[0].d2   = 46'({mag16(up.data.item.axis_z), 29'b0}) + 46'(up.data.nrm);
		nxt[0].dvs  = {up.data.nrm, 1'b0};
		nxt[0].sg0  = up.data.item.axis_x[15];
		nxt[0].sg1  = up.data.item.axis_y[15];
		nxt[0].sg2  = up.data.item.axis_z[15];
		nxt[0].p    = $signed({1'b0, up.data.nrm}) * up.data.item.angle_scale;
		nxt[0].zero = (up.data.nrm == '0);

		// |P| to radians Q28, rounding half up
		nxt[1]     = stg_s[0];
		nxt[1].neg = stg_s[0].p[46];
		absp       = stg_s[0].p[46] ? 46'(-stg_s[0].p) : 46'(stg_s[0].p);
		nxt[1].mag = RW'((absp + (46'd1 << (SH - 1))) >> SH);

		for (int k = 2; k < NS - 1; k++) begin
			nxt[k] = stg_s[k - 1];
			b      = DIV_STEPS - 1 - (k - 2);
			m      = MOD_STEPS - 1 - (k - 2);
			if (b >= 0) begin
				dsh = 46'(stg_s[k - 1].dvs) << b;
				if (stg_s[k - 1].d0 >= dsh) begin
					nxt[k].d0    = stg_s[k - 1].d0 - dsh;
					nxt[k].q0[b] = 1'b1;
				end
				if (stg_s[k - 1].d1 >= dsh) begin
					nxt[k].d1    = stg_s[k - 1].d1 - dsh;
					nxt[k].q1[b] = 1'b1;
				end
				if (stg_s[k - 1].d2 >= dsh) begin
					nxt[k].d2    = stg_s[k - 1].d2 - dsh;
					nxt[k].q2[b] = 1'b1;
				end
			end
			if (m >= 0) begin
				msh = RW'(TWO_PI_Q28) << m;
				if (stg_s[k - 1].mag >= msh) nxt[k].mag = stg_s[k - 1].mag - msh;
			end
		end

		res_nxt.u0   = unit_of(stg_s[NS-2].q0, stg_s[NS-2].sg0);
		res_nxt.u1   = unit_of(stg_s[NS-2].q1, stg_s[NS-2].sg1);
		res_nxt.u2   = unit_of(stg_s[NS-2].q2, stg_s[NS-2].sg2);
		res_nxt.ang  = stg_s[NS-2].mag[30:0];
		res_nxt.neg  = stg_s[NS-2].neg;
		res_nxt.zero = stg_s[NS-2].zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_s[k] <= vld_nxt[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS - 1; k++) begin
			if (adv[k]) stg_s[k] <= nxt[k];
		end
		if (adv[NS-1]) res_s <= res_nxt;
	end

endmodule

>>> rtl/core/aar_cordic.sv
module aar_cordic import aar_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	aar_stream_if.sink    up,
	aar_stream_if.source  dn
);

	// fold, CORDIC rotations, round
	localparam int NS = CORDIC_STEPS + 2;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               flip;
		logic               neg;
		logic               zero;
		logic signed [15:0] u0;
		logic signed [15:0] u1;
		logic signed [15:0] u2;
	} cr_stage_t;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;
	logic [NS-1:0] vld_nxt;
	cr_stage_t     stg_s [NS-1];
	cr_stage_t     nxt [NS-1];
	aar_trig_t     res_s;
	aar_trig_t     res_nxt;

	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || dn.ready;
		for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_s[k] || adv[k + 1];
	end

	assign vld_nxt  = {vld_s[NS-2:0], up.valid};
	assign up.ready = adv[0];
	assign dn.valid = vld_s[NS-1];
	assign dn.data  = res_s;

	always_comb begin
		logic signed [31:0] r;
		logic signed [31:0] dx, dy, at;
		logic signed [31:0] xr, yr;
		logic signed [15:0] cs, sn;
		r            = $signed({1'b0, up.data.ang});
		nxt[0]       = '0;
		nxt[0].x     = CORDIC_GAIN;
		nxt[0].neg   = up.data.neg;
		nxt[0].zero  = up.data.zero;
		nxt[0].u0    = up.data.u0;
		nxt[0].u1    = up.data.u1;
		nxt[0].u2    = up.data.u2;
		// fold into [-pi/2, pi/2]; second and third quadrant flip both outputs
		if (r > HALF_PI_Q28 && r <= THREE_HALF_PI_Q28) begin
			nxt[0].z    = r - PI_Q28;
			nxt[0].flip = 1'b1;
		end else if (r > THREE_HALF_PI_Q28) begin
			nxt[0].z = r - $signed({1'b0, TWO_PI_Q28});
		end else begin
			nxt[0].z = r;
		end

		for (int k = 1; k < NS - 1; k++) begin
			nxt[k] = stg_s[k - 1];
			dx     = stg_s[k - 1].y >>> (k - 1);
			dy     = stg_s[k - 1].x >>> (k - 1);
			at     = atan_q28(5'(k - 1));
			if (!stg_s[k - 1].z[31]) begin
				nxt[k].x = stg_s[k - 1].x - dx;
				nxt[k].y = stg_s[k - 1].y + dy;
				nxt[k].z = stg_s[k - 1].z - at;
			end else begin
				nxt[k].x = stg_s[k - 1].x + dx;
				nxt[k].y = stg_s[k - 1].y - dy;
				nxt[k].z = stg_s[k - 1].z + at;
			end
		end

		xr = (stg_s[NS-2].x + 32'sd8192) >>> 14;
		yr = (stg_s[NS-2].y + 32'sd8192) >>> 14;
		cs = sat_q14(48'(xr));
		sn = sat_q14(48'(yr));
		if (stg_s[NS-2].flip) begin
			cs = -cs;
			sn = -sn;
		end
		if (stg_s[NS-2].neg) sn = -sn;
		res_nxt.u0   = stg_s[NS-2].u0;
		res_nxt.u1   = stg_s[NS-2].u1;
		res_nxt.u2   = stg_s[NS-2].u2;
		res_nxt.sn   = sn;
		res_nxt.v    = 17'sd16384 - 17'(cs);
		res_nxt.zero = stg_s[NS-2].zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_s[k] <= vld_nxt[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS - 1; k++) begin
			if (adv[k]) stg_s[k] <= nxt[k];
		end
		if (adv[NS-1]) res_s <= res_nxt;
	end

endmodule

>>> rtl/core/aar_mat.sv
module aar_mat import aar_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	aar_stream_if.sink    up,
	aar_stream_if.source  dn
);

	localparam int NS = 4;

	typedef struct packed {
		logic signed [29:0] p00;
		logic signed [29:0] p11;
		logic signed [29:0] p22;
		logic signed [29:0] p01;
		logic signed [29:0] p02;
		logic signed [29:0] p12;
		aar_trig_t          trig;
	} mt1_t;

	typedef struct packed {
		logic signed [8:0][30:0] k2;
		logic signed [29:0]      t0;
		logic signed [29:0]      t1;
		logic signed [29:0]      t2;
		logic signed [16:0]      v;
		logic                    zero;
	} mt2_t;

	typedef struct packed {
		logic signed [8:0][47:0] vk;
		logic signed [8:0][30:0] sk;
		logic                    zero;
	} mt3_t;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;
	logic [NS-1:0] vld_nxt;
	mt1_t          mt_s1, mt_n1;
	mt2_t          mt_s2, mt_n2;
	mt3_t          mt_s3, mt_n3;
	aar_out_t      out_s4, out_n4;

	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || dn.ready;
		for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_s[k] || adv[k + 1];
	end

	assign vld_nxt  = {vld_s[NS-2:0], up.valid};
	assign up.ready = adv[0];
	assign dn.valid = vld_s[NS-1];
	assign dn.data  = out_s4;

	always_comb begin
		logic signed [47:0] acc;
		logic signed [15:0] m [9];
		mt_n1.p00  = up.data.u0 * up.data.u0;
		mt_n1.p11  = up.data.u1 * up.data.u1;
		mt_n1.p22  = up.data.u2 * up.data.u2;
		mt_n1.p01  = up.data.u0 * up.data.u1;
		mt_n1.p02  = up.data.u0 * up.data.u2;
		mt_n1.p12  = up.data.u1 * up.data.u2;
		mt_n1.trig = up.data;

		// K*K: diagonal is minus the other two squares, off-diagonal ui*uj
		mt_n2.k2[0] = -(31'(mt_s1.p11) + 31'(mt_s1.p22));
		mt_n2.k2[1] = 31'(mt_s1.p01);
		mt_n2.k2[2] = 31'(mt_s1.p02);
		mt_n2.k2[3] = 31'(mt_s1.p01);
		mt_n2.k2[4] = -(31'(mt_s1.p00) + 31'(mt_s1.p22));
		mt_n2.k2[5] = 31'(mt_s1.p12);
		mt_n2.k2[6] = 31'(mt_s1.p02);
		mt_n2.k2[7] = 31'(mt_s1.p12);
		mt_n2.k2[8] = -(31'(mt_s1.p00) + 31'(mt_s1.p11));
		mt_n2.t0    = mt_s1.trig.sn * mt_s1.trig.u0;
		mt_n2.t1    = mt_s1.trig.sn * mt_s1.trig.u1;
		mt_n2.t2    = mt_s1.trig.sn * mt_s1.trig.u2;
		mt_n2.v     = mt_s1.trig.v;
		mt_n2.zero  = mt_s1.trig.zero;

		// elements of a packed array select as unsigned
		for (int i = 0; i < 9; i++) mt_n3.vk[i] = mt_s2.v * $signed(mt_s2.k2[i]);
		mt_n3.sk[0] = '0;
		mt_n3.sk[1] = -31'(mt_s2.t2);
		mt_n3.sk[2] = 31'(mt_s2.t1);
		mt_n3.sk[3] = 31'(mt_s2.t2);
		mt_n3.sk[4] = '0;
		mt_n3.sk[5] = -31'(mt_s2.t0);
		mt_n3.sk[6] = -31'(mt_s2.t1);
		mt_n3.sk[7] = 31'(mt_s2.t0);
		mt_n3.sk[8] = '0;
		mt_n3.zero  = mt_s2.zero;

		for (int i = 0; i < 9; i++) begin
			acc = $signed(mt_s3.vk[i]) + (48'($signed(mt_s3.sk[i])) <<< 14);
			if (i % 4 == 0) acc = acc + (48'sd1 <<< 42);
			m[i] = mt_s3.zero ? ((i % 4 == 0) ? ONE_Q14 : 16'sd0)
				: sat_q14((acc + 48'sd134217728) >>> 28);
		end
		out_n4.m00       = m[0];
		out_n4.m01       = m[1];
		out_n4.m02       = m[2];
		out_n4.m10       = m[3];
		out_n4.m11       = m[4];
		out_n4.m12       = m[5];
		out_n4.m20       = m[6];
		out_n4.m21       = m[7];
		out_n4.m22       = m[8];
		out_n4.zero_axis = mt_s3.zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_s[k] <= vld_nxt[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) mt_s1 <= mt_n1;
		if (adv[1]) mt_s2 <= mt_n2;
		if (adv[2]) mt_s3 <= mt_n3;
		if (adv[3]) out_s4 <= out_n4;
	end

endmodule

>>> rtl/core/axis_angle_rotation_matrix.sv
// channel  side  word
// req      in    axis_x, axis_y, axis_z, angle_scale (Q4.12 at FRAC_BITS = 12)
// rsp      out   m00 .. m22 (Q1.14, saturated to +-1), zero_axis
//
// One word enters per cycle unless a stall has backed up to the input. The
// stages run in order: norm root (one bit a stage), unit vector division and
// angle modulo steps, CORDIC, matrix.
// Reset clears only the stage valid bits; no clearing pass.
// A stall holds full stages in place; empty stages upstream keep filling.
module axis_angle_rotation_matrix import aar_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	aar_stream_if.sink    req,
	aar_stream_if.source  rsp
);

	aar_stream_if #(.payload_t(aar_nrm_t))  nrm_l ();
	aar_stream_if #(.payload_t(aar_unit_t)) unit_l ();
	aar_stream_if #(.payload_t(aar_trig_t)) trig_l ();

	aar_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (req),
		.dn     (nrm_l)
	);

	aar_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (nrm_l),
		.dn     (unit_l)
	);

	aar_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (unit_l),
		.dn     (trig_l)
	);

	aar_mat u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (trig_l),
		.dn     (rsp)
	);

	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.zero_axis |->
			rsp.data.m00 == ONE_Q14 && rsp.data.m11 == ONE_Q14 && rsp.data.m22 == ONE_Q14
			&& rsp.data.m01 == 16'sd0 && rsp.data.m12 == 16'sd0 && rsp.data.m20 == 16'sd0)
		else $error("zero axis word is not the identity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.m00 <= ONE_Q14 && rsp.data.m00 >= -ONE_Q14
			&& rsp.data.m12 <= ONE_Q14 && rsp.data.m12 >= -ONE_Q14)
		else $error("matrix entry out of range");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.ready |-> req.ready)
		else $error("pipeline blocks input while output drains");

endmodule
